FILE: rtl/md5he_pkg.sv
// ----------------------------------------------------------------------------
// md5he_pkg
// Shared types, round constants and helper functions of the MD5 engine.
// ----------------------------------------------------------------------------
package md5he_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_ADD
    } state_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } round_t;

    localparam logic [31:0] PAD_BYTE   = 32'h0000_0080;
    localparam logic [5:0]  LAST_THIRD = 6'd48;
    localparam logic [5:0]  LAST_ROUND = 6'd63;
    localparam logic [3:0]  LEN_LO_SLOT = 4'd14;
    localparam logic [3:0]  LAST_SLOT   = 4'd15;
    localparam logic [2:0]  FULL_COUNT  = 3'd4;

    localparam logic [31:0] INIT_VALUE [4] = '{
        32'h6745_2301, 32'hefcd_ab89, 32'h98ba_dcfe, 32'h1032_5476
    };

    localparam logic [31:0] SINE_ADD [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] SHIFT_AMT [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22,
        5'd5, 5'd9,  5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23,
        5'd6, 5'd10, 5'd15, 5'd21
    };

    function automatic logic [3:0] msg_index(input logic [5:0] r);
        logic [3:0] lo;
        logic [3:0] idx;
        lo = r[3:0];
        unique case (r[5:4])
            2'd0:    idx = lo;
            2'd1:    idx = 4'(lo * 4'd5 + 4'd1);
            2'd2:    idx = 4'(lo * 4'd3 + 4'd5);
            default: idx = 4'(lo * 4'd7);
        endcase
        return idx;
    endfunction

    function automatic logic [31:0] mix_func(input logic [5:0] r, input round_t x);
        logic [31:0] f;
        if (r < 6'd16) begin
            f = (x.b & x.c) | (~x.b & x.d);
        end else if (r < 6'd32) begin
            f = (x.b & x.d) | (x.c & ~x.d);
        end else if (r < LAST_THIRD) begin
            f = x.b ^ x.c ^ x.d;
        end else begin
            f = x.c ^ (x.b | ~x.d);
        end
        return f;
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
        logic [63:0] dbl;
        dbl = {x, x} << s;
        return dbl[63:32];
    endfunction

endpackage

FILE: rtl/md5_hash_engine_unit.sv
// ----------------------------------------------------------------------------
// md5_hash_engine_unit
// MD5 digest engine over a stream of little-endian 32-bit message words. Each
// word is written into a 16-entry block RAM; the sixteenth word starts the
// compression, which runs one round per cycle off the RAM's read port and
// then folds the result into the chaining value; no word is taken while the
// engine compresses or pads. On the last word the engine writes the padding
// and the bit length one word per cycle between compressions, runs one or two
// more compressions, and hands the four digest words (A to D) to an output
// buffer, so the next message can be taken while they drain.
// ----------------------------------------------------------------------------
module md5_hash_engine_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_data_word,
    input  logic [2:0]  s_byte_count,
    input  logic        s_last_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [1:0]  m_word_number,
    output logic        m_digest_done
);

    md5he_pkg::state_t state_reg, state_next;
    logic [5:0]  step_reg, step_next;
    logic [3:0]  slot_reg, slot_next;
    logic [63:0] bit_total_reg, bit_total_next;
    logic [31:0] chain_reg [4];
    logic [31:0] chain_next [4];
    md5he_pkg::round_t rnd_reg, rnd_next, rnd_step;
    logic        pad80_reg, pad80_next;
    logic        pad_reg, pad_next;
    logic        len_reg, len_next;
    logic        final_reg, final_next;
    logic [31:0] out_word_reg [4];
    logic [31:0] out_word_next [4];
    logic        out_busy_reg, out_busy_next;
    logic [1:0]  out_idx_reg, out_idx_next;

    logic        wr_en;
    logic [31:0] wr_data;
    logic [3:0]  rd_addr;
    logic [31:0] rd_data;
    logic [2:0]  count;

    md5he_ram #(
        .WIDTH (32),
        .DEPTH (16)
    ) u_block_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (slot_reg),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    md5he_round u_round (
        .step     (step_reg),
        .rnd      (rnd_reg),
        .msg_word (rd_data),
        .rnd_out  (rnd_step)
    );

    assign count = (s_byte_count > md5he_pkg::FULL_COUNT) ? md5he_pkg::FULL_COUNT
                                                          : s_byte_count;
    assign rd_addr = (state_reg == md5he_pkg::ST_COMP)
                   ? md5he_pkg::msg_index(6'(step_reg + 6'd1)) : 4'd0;

    assign s_ready       = (state_reg == md5he_pkg::ST_IDLE);
    assign m_valid       = out_busy_reg;
    assign m_digest_word = out_word_reg[out_idx_reg];
    assign m_word_number = out_idx_reg;
    assign m_digest_done = (out_idx_reg == 2'd3);

    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        slot_next      = slot_reg;
        bit_total_next = bit_total_reg;
        chain_next     = chain_reg;
        rnd_next       = rnd_reg;
        pad80_next     = pad80_reg;
        pad_next       = pad_reg;
        len_next       = len_reg;
        final_next     = final_reg;
        out_word_next  = out_word_reg;
        out_busy_next  = out_busy_reg;
        out_idx_next   = out_idx_reg;
        wr_en          = 1'b0;
        wr_data        = '0;

        if (out_busy_reg && m_ready) begin
            out_idx_next = 2'(out_idx_reg + 2'd1);
            if (out_idx_reg == 2'd3) begin
                out_busy_next = 1'b0;
            end
        end

        unique case (state_reg)
            md5he_pkg::ST_IDLE: begin
                if (s_valid) begin
                    wr_en = 1'b1;
                    if (!s_last_word) begin
                        wr_data        = s_data_word;
                        bit_total_next = bit_total_reg + 64'd32;
                    end else begin
                        bit_total_next = bit_total_reg + (64'(count) << 3);
                        pad_next       = 1'b1;
                        unique case (count)
                            3'd0: wr_data = md5he_pkg::PAD_BYTE;
                            3'd1: wr_data = {16'h0000, 8'h80, s_data_word[7:0]};
                            3'd2: wr_data = {8'h00, 8'h80, s_data_word[15:0]};
                            3'd3: wr_data = {8'h80, s_data_word[23:0]};
                            default: begin
                                wr_data    = s_data_word;
                                pad80_next = 1'b1;
                            end
                        endcase
                    end
                    slot_next = 4'(slot_reg + 4'd1);
                    if (slot_reg == md5he_pkg::LAST_SLOT) begin
                        rnd_next   = '{a: chain_reg[0], b: chain_reg[1],
                                       c: chain_reg[2], d: chain_reg[3]};
                        step_next  = '0;
                        state_next = md5he_pkg::ST_COMP;
                    end else if (s_last_word) begin
                        state_next = md5he_pkg::ST_PAD;
                    end
                end
            end
            md5he_pkg::ST_PAD: begin
                wr_en = 1'b1;
                if (pad80_reg) begin
                    wr_data    = md5he_pkg::PAD_BYTE;
                    pad80_next = 1'b0;
                end else if (slot_reg == md5he_pkg::LEN_LO_SLOT) begin
                    wr_data  = bit_total_reg[31:0];
                    len_next = 1'b1;
                end else if (slot_reg == md5he_pkg::LAST_SLOT && len_reg) begin
                    wr_data    = bit_total_reg[63:32];
                    len_next   = 1'b0;
                    pad_next   = 1'b0;
                    final_next = 1'b1;
                end else begin
                    wr_data = '0;
                end
                slot_next = 4'(slot_reg + 4'd1);
                if (slot_reg == md5he_pkg::LAST_SLOT) begin
                    rnd_next   = '{a: chain_reg[0], b: chain_reg[1],
                                   c: chain_reg[2], d: chain_reg[3]};
                    step_next  = '0;
                    state_next = md5he_pkg::ST_COMP;
                end
            end
            md5he_pkg::ST_COMP: begin
                rnd_next  = rnd_step;
                step_next = 6'(step_reg + 6'd1);
                if (step_reg == md5he_pkg::LAST_ROUND) begin
                    state_next = md5he_pkg::ST_ADD;
                end
            end
            md5he_pkg::ST_ADD: begin
                if (final_reg) begin
                    if (!out_busy_reg) begin
                        out_word_next[0] = chain_reg[0] + rnd_reg.a;
                        out_word_next[1] = chain_reg[1] + rnd_reg.b;
                        out_word_next[2] = chain_reg[2] + rnd_reg.c;
                        out_word_next[3] = chain_reg[3] + rnd_reg.d;
                        out_busy_next    = 1'b1;
                        out_idx_next     = '0;
                        chain_next       = md5he_pkg::INIT_VALUE;
                        bit_total_next   = '0;
                        final_next       = 1'b0;
                        state_next       = md5he_pkg::ST_IDLE;
                    end
                end else begin
                    chain_next[0] = chain_reg[0] + rnd_reg.a;
                    chain_next[1] = chain_reg[1] + rnd_reg.b;
                    chain_next[2] = chain_reg[2] + rnd_reg.c;
                    chain_next[3] = chain_reg[3] + rnd_reg.d;
                    state_next    = pad_reg ? md5he_pkg::ST_PAD : md5he_pkg::ST_IDLE;
                end
            end
            default: state_next = md5he_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= md5he_pkg::ST_IDLE;
            step_reg      <= '0;
            slot_reg      <= '0;
            bit_total_reg <= '0;
            chain_reg     <= md5he_pkg::INIT_VALUE;
            pad80_reg     <= 1'b0;
            pad_reg       <= 1'b0;
            len_reg       <= 1'b0;
            final_reg     <= 1'b0;
            out_busy_reg  <= 1'b0;
            out_idx_reg   <= '0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            slot_reg      <= slot_next;
            bit_total_reg <= bit_total_next;
            chain_reg     <= chain_next;
            pad80_reg     <= pad80_next;
            pad_reg       <= pad_next;
            len_reg       <= len_next;
            final_reg     <= final_next;
            out_busy_reg  <= out_busy_next;
            out_idx_reg   <= out_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        rnd_reg      <= rnd_next;
        out_word_reg <= out_word_next;
    end

`ifndef SYNTHESIS
    a_no_write_in_rounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == md5he_pkg::ST_COMP || state_reg == md5he_pkg::ST_ADD) |-> !wr_en)
        else $error("block RAM written during compression");

    a_rounds_end_in_add: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == md5he_pkg::ST_COMP && step_reg == md5he_pkg::LAST_ROUND)
        |=> state_reg == md5he_pkg::ST_ADD)
        else $error("compression did not finish after the last round");

    a_compress_on_full_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && slot_reg == md5he_pkg::LAST_SLOT)
        |=> state_reg == md5he_pkg::ST_COMP && step_reg == 6'd0 && slot_reg == 4'd0)
        else $error("full block did not start compression");

    a_final_has_empty_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == md5he_pkg::ST_ADD && final_reg) |-> slot_reg == 4'd0 && !pad_reg)
        else $error("digest finished with a partial block");

    a_done_on_last_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_digest_done) |=> !m_valid || out_idx_reg == 2'd0)
        else $error("digest buffer did not drain after word D");
`endif

endmodule

FILE: rtl/md5he_ram.sv
// ----------------------------------------------------------------------------
// md5he_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module md5he_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: rtl/md5he_round.sv
// ----------------------------------------------------------------------------
// md5he_round
// One MD5 round: mixing function, constant and message add, rotate, add B.
// ----------------------------------------------------------------------------
module md5he_round (
    input  logic [5:0]          step,
    input  md5he_pkg::round_t   rnd,
    input  logic [31:0]         msg_word,
    output md5he_pkg::round_t   rnd_out
);

    logic [31:0] sum;
    logic [3:0]  shift_sel;

    assign shift_sel = {step[5:4], step[1:0]};
    assign sum = md5he_pkg::mix_func(step, rnd) + rnd.a
               + md5he_pkg::SINE_ADD[step] + msg_word;

    always_comb begin
        rnd_out.a = rnd.d;
        rnd_out.b = rnd.b + md5he_pkg::rotl32(sum, md5he_pkg::SHIFT_AMT[shift_sel]);
        rnd_out.c = rnd.b;
        rnd_out.d = rnd.c;
    end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for md5_hash_engine_unit. A directed message table
// (known digests typed in, the rest predicted) is followed by random messages
// under four handshake mixes and a long output hold-off. An MD5 model predicts
// the other digests; every digest word is checked in order at the output.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_CYCLES = 300;
    localparam int HOLD_CYCLES  = 700;
    localparam int PHASE_WORDS  = 28;

    localparam logic [31:0] PAD_MARK = 32'h0000_0080;
    localparam logic [2:0]  WHOLE_WORD = 3'd4;
    localparam logic [3:0]  LEN_SLOT = 4'd14;

    localparam logic [127:0] DIG_EMPTY = 128'hd98c1dd4_04b2008f_980980e9_7e42f8ec;
    localparam logic [127:0] DIG_ABC   = 128'h98500190_b04fd23c_7d3f96d6_727fe128;
    localparam logic [127:0] DIG_A     = 128'hb975c10c_a8b6f1c0_e299c331_61267769;

    localparam logic [31:0] IV_WORDS [4] = '{
        32'h6745_2301, 32'hefcd_ab89, 32'h98ba_dcfe, 32'h1032_5476
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROT_AMT [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22,
        5'd5, 5'd9,  5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23,
        5'd6, 5'd10, 5'd15, 5'd21
    };

    // message lengths (in words) that put the last word near the length slots
    localparam int EDGE_LEN [8] = '{13, 14, 15, 16, 29, 30, 31, 32};

    localparam int SRC_IDLE [4] = '{0, 47, 0, 35};
    localparam int SNK_STALL [4] = '{0, 0, 47, 35};

    typedef struct packed {
        logic [31:0]  data;
        logic [2:0]   cnt;
        logic         last;
        logic         known;
        logic [127:0] dig;
    } stim_row_t;

    localparam stim_row_t DIR_ROWS [12] = '{
        '{32'hffff_ffff, 3'd0, 1'b1, 1'b1, DIG_EMPTY},
        '{32'hff63_6261, 3'd3, 1'b1, 1'b1, DIG_ABC},
        '{32'hdead_be61, 3'd1, 1'b1, 1'b1, DIG_A},
        '{32'h0000_0000, 3'd0, 1'b0, 1'b0, 128'd0},
        '{32'hffff_ffff, 3'd5, 1'b0, 1'b0, 128'd0},
        '{32'hffff_ffff, 3'd6, 1'b1, 1'b0, 128'd0},
        '{32'h8000_0000, 3'd4, 1'b1, 1'b0, 128'd0},
        '{32'ha5a5_a5a5, 3'd7, 1'b0, 1'b0, 128'd0},
        '{32'h5a5a_5a5a, 3'd2, 1'b1, 1'b0, 128'd0},
        '{32'h0000_0001, 3'd2, 1'b0, 1'b0, 128'd0},
        '{32'hffff_fffe, 3'd3, 1'b0, 1'b0, 128'd0},
        '{32'h7fff_ffff, 3'd7, 1'b1, 1'b0, 128'd0}
    };

    typedef struct {
        logic [31:0] dig_word;
        logic [1:0]  dig_num;
        logic        dig_done;
    } digest_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_data_word;
    logic [2:0]  s_byte_count;
    logic        s_last_word;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_digest_word;
    logic [1:0]  m_word_number;
    logic        m_digest_done;

    // behavioral hash state
    logic [31:0] chain_st [4];
    logic [31:0] block_st [16];
    logic [63:0] msg_bits;
    logic [3:0]  fill_slot;
    logic [31:0] calc_digest [4];

    digest_t digest_q [$];
    digest_t got_exp;

    int fail_count = 0;
    int words_sent = 0;
    int messages_sent = 0;
    int digests_checked = 0;
    int cycle_count = 0;
    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int hold_left = 0;
    bit hold_req = 1'b0;

    md5_hash_engine_unit u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_word   (s_data_word),
        .s_byte_count  (s_byte_count),
        .s_last_word   (s_last_word),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_digest_word (m_digest_word),
        .m_word_number (m_word_number),
        .m_digest_done (m_digest_done)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic void md5_restart();
        for (int k = 0; k < 4; k++) chain_st[k] = IV_WORDS[k];
        msg_bits = 64'd0;
        fill_slot = 4'd0;
    endfunction

    function automatic void md5_compress();
        logic [31:0] a, b, c, d, f;
        logic [3:0]  g;
        logic [4:0]  s;
        a = chain_st[0];
        b = chain_st[1];
        c = chain_st[2];
        d = chain_st[3];
        for (int r = 0; r < 64; r++) begin
            case (r / 16)
                0: begin
                    f = (b & c) | (~b & d);
                    g = 4'(r);
                end
                1: begin
                    f = (b & d) | (c & ~d);
                    g = 4'(5 * r + 1);
                end
                2: begin
                    f = b ^ c ^ d;
                    g = 4'(3 * r + 5);
                end
                default: begin
                    f = c ^ (b | ~d);
                    g = 4'(7 * r);
                end
            endcase
            f = f + a + ROUND_K[r] + block_st[g];
            s = ROT_AMT[(r / 16) * 4 + r % 4];
            f = ((f << s) | (f >> (32 - s))) + b;
            a = d;
            d = c;
            c = b;
            b = f;
        end
        chain_st[0] = chain_st[0] + a;
        chain_st[1] = chain_st[1] + b;
        chain_st[2] = chain_st[2] + c;
        chain_st[3] = chain_st[3] + d;
    endfunction

    function automatic void md5_put(input logic [31:0] w);
        block_st[fill_slot] = w;
        fill_slot = fill_slot + 4'd1;
        if (fill_slot == 4'd0) md5_compress();
    endfunction

    // absorb one input word; returns 1 when the message completes
    function automatic bit md5_absorb(input logic [31:0] d, input logic [2:0] c,
                                      input logic l);
        logic [2:0]  n;
        logic [31:0] keep;
        bit          done;
        n = (c > WHOLE_WORD) ? WHOLE_WORD : c;
        done = 1'b0;
        if (!l) begin
            msg_bits = msg_bits + 64'd32;
            md5_put(d);
        end else begin
            msg_bits = msg_bits + 64'({n, 3'b000});
            if (n == WHOLE_WORD) begin
                md5_put(d);
                md5_put(PAD_MARK);
            end else begin
                keep = (32'd1 << (8 * n)) - 32'd1;
                md5_put((d & keep) | (PAD_MARK << (8 * n)));
            end
            if (fill_slot > LEN_SLOT)
                while (fill_slot != 4'd0) md5_put(32'd0);
            while (fill_slot < LEN_SLOT) md5_put(32'd0);
            md5_put(msg_bits[31:0]);
            md5_put(msg_bits[63:32]);
            for (int k = 0; k < 4; k++) calc_digest[k] = chain_st[k];
            md5_restart();
            done = 1'b1;
        end
        return done;
    endfunction

    // drive one transaction; entered and left just after a falling edge
    task automatic send_word(input logic [31:0] d, input logic [2:0] c, input logic l,
                             input logic known, input logic [127:0] known_dig);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_data_word  <= d;
        s_byte_count <= c;
        s_last_word  <= l;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
        if (md5_absorb(d, c, l)) begin
            messages_sent++;
            for (int k = 0; k < 4; k++)
                digest_q.push_back(digest_t'{
                    known ? known_dig[127 - 32 * k -: 32] : calc_digest[k],
                    2'(k), k == 3});
        end
        @(negedge aclk);
    endtask

    task automatic send_message(input int len);
        logic [2:0] c;
        for (int i = 0; i < len - 1; i++) begin
            c = ($urandom_range(99) < 10) ? 3'($urandom_range(7)) : WHOLE_WORD;
            send_word($urandom, c, 1'b0, 1'b0, 128'd0);
        end
        send_word($urandom, 3'($urandom_range(7)), 1'b1, 1'b0, 128'd0);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (digest_q.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // result side: random stalls plus one long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (digest_q.size() == 0) begin
                $display("%0t: unexpected digest word %0d = %h (done %b)", $time,
                         m_word_number, m_digest_word, m_digest_done);
                fail_count++;
            end else begin
                got_exp = digest_q.pop_front();
                if (got_exp.dig_word !== m_digest_word || got_exp.dig_num !== m_word_number
                        || got_exp.dig_done !== m_digest_done) begin
                    $display("%0t: digest mismatch: expected word %0d = %h (done %b),",
                             $time, got_exp.dig_num, got_exp.dig_word, got_exp.dig_done,
                             " got word %0d = %h (done %b)",
                             m_word_number, m_digest_word, m_digest_done);
                    fail_count++;
                end
                digests_checked++;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d digest words outstanding", $time, digest_q.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int msg_idx;
        int phase_words;
        int len;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data_word  = 32'd0;
        s_byte_count = 3'd0;
        s_last_word  = 1'b0;
        msg_idx      = 0;
        md5_restart();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < 12; i++)
            send_word(DIR_ROWS[i].data, DIR_ROWS[i].cnt, DIR_ROWS[i].last,
                      DIR_ROWS[i].known, DIR_ROWS[i].dig);
        drain_results();

        for (int ph = 0; ph < 4; ph++) begin
            src_idle_pct = SRC_IDLE[ph];
            snk_stall_pct = SNK_STALL[ph];
            phase_words = 0;
            while (phase_words < PHASE_WORDS) begin
                len = (msg_idx % 2 == 0) ? EDGE_LEN[(msg_idx / 2) % 8] : $urandom_range(1, 34);
                send_message(len);
                phase_words += len;
                msg_idx++;
            end
            // hold the input until every digest of the phase is out
            drain_results();
        end

        // block the output and keep offering so the engine backs up
        src_idle_pct = 0;
        snk_stall_pct = 0;
        hold_req = 1'b1;
        repeat (3) send_message(20);
        drain_results();

        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Covered %0d messages in %0d words, %0d digest words checked,", messages_sent,
                 words_sent, digests_checked);
        $display("across idle/stall mixes, a long output hold-off and padding edge lengths.");
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
